// ----- src/rational_map_escape_time_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the rational map escape-time core
// Implication and next-cycle implication forms, reset-gated, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_MAP_ESCAPE_TIME_CORE_ASSERT_SVH
`define RATIONAL_MAP_ESCAPE_TIME_CORE_ASSERT_SVH

// same-cycle implication
`define RMET_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RMET_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/rmet_pkg.sv -----
// ----------------------------------------------------------------------------
// rmet_pkg
// Shared widths, register reset values, result codes and the divider stage
// type for the rational map escape-time core.
// ----------------------------------------------------------------------------
package rmet_pkg;

  // field widths
  localparam int unsigned POINT_W  = 32;
  localparam int unsigned NORM_W   = 64;
  localparam int unsigned ITER_W   = 10;
  localparam int unsigned COLOUR_W = 15;

  // fixed-point formats
  localparam int unsigned FRACTION_BITS_DEF = 24;
  localparam int unsigned NORM_FRAC         = 40;

  // iteration cap applied on top of the limit register
  localparam int unsigned ITER_CEILING = 1023;

  // quotient bits resolved by the divider cells (overflow is checked apart)
  localparam int unsigned QUOT_BITS = 31;

  // configuration port
  localparam int unsigned PADDR_W = 6;
  localparam int unsigned PDATA_W = 64;

  // register reset values
  localparam logic signed [POINT_W-1:0] A_REAL_RST     = 32'sd0;
  localparam logic signed [POINT_W-1:0] A_IMAG_RST     = 32'sd15099494;
  localparam logic [ITER_W-1:0]         ITER_LIMIT_RST = 10'd50;
  localparam logic [NORM_W-1:0]         SMALL_NORM_RST = 64'd1099512;
  localparam logic [NORM_W-1:0]         LARGE_NORM_RST = 64'd1099511627776000000;

  // colour code
  localparam int unsigned         COLOUR_STEP   = 10;
  localparam int unsigned         COLOUR_INWARD = 65;
  localparam logic [COLOUR_W-1:0] COLOUR_NONE   = '1;

  typedef enum logic [1:0] {
    KIND_OUTWARD = 2'd0,
    KIND_INWARD  = 2'd1,
    KIND_LIMIT   = 2'd2
  } escape_kind_e;

  // one slot of the divider chain
  typedef struct packed {
    logic                 valid;
    logic [NORM_W-1:0]    rem;
    logic [QUOT_BITS-1:0] low;
    logic [QUOT_BITS-1:0] quot;
  } div_stage_t;

endpackage

// ----- src/rmet_if.sv -----
// ----------------------------------------------------------------------------
// rmet_if
// Valid/ready channels for start points and for escape-time results.
// ----------------------------------------------------------------------------
interface rmet_in_if;
  import rmet_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [POINT_W-1:0]  start_real;
  logic signed [POINT_W-1:0]  start_imag;

  modport source (output valid, output start_real, output start_imag, input ready);
  modport sink   (input valid, input start_real, input start_imag, output ready);
endinterface

interface rmet_out_if;
  import rmet_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [COLOUR_W-1:0]  colour_code;
  logic [ITER_W-1:0]           iterations_done;
  logic [1:0]                  escape_kind;

  modport source (output valid, output colour_code, output iterations_done,
                  output escape_kind, input ready);
  modport sink   (input valid, input colour_code, input iterations_done,
                  input escape_kind, output ready);
endinterface

// ----- src/rational_map_escape_time_core.sv -----
// Schedule: each map application runs 20 products through the shared multiplier, each
//   in a multiply and an accumulate state, then the 31 divider cells; an application
//   whose denominator is zero ends before the divider; output stalls add to the time.
// Throughput: one item in flight; the next is taken once the result sits in the
//   output register. The shared 32x32 multiplier and the two 31-cell divider chains set the rate.
// Reset: asynchronous, active low; clears control state and loads register defaults.
// ----------------------------------------------------------------------------
// rational_map_escape_time_core
// Escape-time iteration of x -> x*x*(a*x-1)/(x-a) in fixed point, with an
// APB-style register port for the map parameter, limit and norm band.
// ----------------------------------------------------------------------------
module rational_map_escape_time_core #(
  parameter int unsigned FRACTION_BITS = rmet_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rmet_pkg::PADDR_W-1:0]  paddr,
  input  logic [rmet_pkg::PDATA_W-1:0]  pwdata,
  output logic [rmet_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  rmet_in_if.sink                       in_i,
  rmet_out_if.source                    out_o
);
  import rmet_pkg::*;

  localparam int unsigned DN    = (2*FRACTION_BITS > NORM_FRAC) ?
                                  2*FRACTION_BITS - NORM_FRAC : 0;
  localparam int unsigned UP    = (2*FRACTION_BITS < NORM_FRAC) ?
                                  NORM_FRAC - 2*FRACTION_BITS : 0;
  localparam int unsigned OVF_W = NORM_W + 1 +
                                  ((FRACTION_BITS > QUOT_BITS) ? FRACTION_BITS : QUOT_BITS);
  localparam int unsigned DVD_W = NORM_W + FRACTION_BITS;
  localparam logic signed [63:0] ONE      = 64'sd1 <<< FRACTION_BITS;
  localparam logic [NORM_W-1:0]  NORM_MAX = '1;
  localparam logic [NORM_W-1:0]  NORM_ONE = 64'd1 << NORM_FRAC;

  typedef enum logic [2:0] {
    REG_A_REAL     = 3'd0,
    REG_A_IMAG     = 3'd1,
    REG_ITER_LIMIT = 3'd2,
    REG_SMALL_NORM = 3'd3,
    REG_LARGE_NORM = 3'd4
  } reg_idx_e;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_ACC   = 7'b0001000,
    S_DIVST = 7'b0010000,
    S_DIVW  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  // product schedule of one map application
  typedef enum logic [4:0] {
    OP_NRM_A = 5'd0,  OP_NRM_B = 5'd1,
    OP_SQR_A = 5'd2,  OP_SQR_B = 5'd3,
    OP_SQI_A = 5'd4,  OP_SQI_B = 5'd5,
    OP_AXR_A = 5'd6,  OP_AXR_B = 5'd7,
    OP_AXI_A = 5'd8,  OP_AXI_B = 5'd9,
    OP_NUR_A = 5'd10, OP_NUR_B = 5'd11,
    OP_NUI_A = 5'd12, OP_NUI_B = 5'd13,
    OP_DEN_A = 5'd14, OP_DEN_B = 5'd15,
    OP_QR_A  = 5'd16, OP_QR_B  = 5'd17,
    OP_QI_A  = 5'd18, OP_QI_B  = 5'd19
  } op_e;

  function automatic logic signed [63:0] sx64(input logic signed [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic signed [63:0] sat64(input logic signed [64:0] v);
    if (v[64] != v[63]) return v[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    return v[63:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v[63:31] != {33{v[63]}}) return v[63] ? 32'sh80000000 : 32'sh7fffffff;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] quot_fin(input logic ovf, input logic neg,
                                                  input logic [QUOT_BITS-1:0] q);
    logic [31:0] m;
    m = {1'b0, q};
    if (ovf) return neg ? 32'sh80000000 : 32'sh7fffffff;
    return neg ? (32'd0 - m) : m;
  endfunction

  // ---------------- configuration registers ----------------
  logic signed [POINT_W-1:0] a_real_q, a_imag_q;
  logic [ITER_W-1:0]         iter_limit_q;
  logic [NORM_W-1:0]         small_norm_q, large_norm_q;
  logic                      cfg_we;
  logic [2:0]                cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = paddr[PADDR_W-1:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_real_q     <= A_REAL_RST;
      a_imag_q     <= A_IMAG_RST;
      iter_limit_q <= ITER_LIMIT_RST;
      small_norm_q <= SMALL_NORM_RST;
      large_norm_q <= LARGE_NORM_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_e'(cfg_idx))
        REG_A_REAL:     a_real_q     <= pwdata[POINT_W-1:0];
        REG_A_IMAG:     a_imag_q     <= pwdata[POINT_W-1:0];
        REG_ITER_LIMIT: iter_limit_q <= pwdata[ITER_W-1:0];
        REG_SMALL_NORM: small_norm_q <= pwdata;
        REG_LARGE_NORM: large_norm_q <= pwdata;
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (reg_idx_e'(cfg_idx))
      REG_A_REAL:     prdata = {32'd0, a_real_q};
      REG_A_IMAG:     prdata = {32'd0, a_imag_q};
      REG_ITER_LIMIT: prdata = {54'd0, iter_limit_q};
      REG_SMALL_NORM: prdata = small_norm_q;
      REG_LARGE_NORM: prdata = large_norm_q;
      default:        prdata = '0;
    endcase
  end

  // ---------------- iteration state ----------------
  state_e                    state_q, state_d;
  op_e                       op_q;
  logic [ITER_W-1:0]         iter_q, lim;
  logic                      blown_q;
  escape_kind_e              kind_q;
  logic signed [31:0]        xr_q, xi_q, tr_q, ti_q, ur_q, ui_q, nr_q, ni_q, dr_q, di_q;
  logic [NORM_W-1:0]         den_q;
  logic signed [63:0]        qr_q, qi_q;
  logic signed [63:0]        prod_q, prod_d;
  logic signed [64:0]        acc_q, acc_d, prod_ext;
  logic signed [31:0]        mul_a, mul_b;
  logic signed [31:0]        cm;
  logic [NORM_W-1:0]         sq_sum, norm;
  logic                      in_band, in_acc, out_free, at_limit;
  logic                      ovf_r_q, ovf_i_q, neg_r_q, neg_i_q;

  // escape reporting
  logic                      out_valid_q;
  logic [COLOUR_W-1:0]       colour_q, colour_d, iter_ext;
  logic [ITER_W-1:0]         iter_out_q;
  logic [1:0]                kind_out_q;

  // divider
  logic [NORM_W-1:0]         mag_r, mag_i;
  logic [DVD_W-1:0]          dvd_r, dvd_i;
  div_stage_t                div_in_r, div_in_i, div_out_r, div_out_i;

  assign lim      = (32'(iter_limit_q) > ITER_CEILING) ? ITER_W'(ITER_CEILING) : iter_limit_q;
  assign in_acc   = in_i.valid & in_i.ready;
  assign out_free = ~out_valid_q | out_o.ready;
  assign at_limit = (iter_q >= lim);
  assign in_i.ready = (state_q == S_IDLE);

  // multiplier operand select
  always_comb begin
    unique case (op_q)
      OP_NRM_A, OP_SQR_A: begin mul_a = xr_q;     mul_b = xr_q; end
      OP_NRM_B, OP_SQR_B: begin mul_a = xi_q;     mul_b = xi_q; end
      OP_SQI_A:           begin mul_a = xr_q;     mul_b = xi_q; end
      OP_SQI_B:           begin mul_a = xi_q;     mul_b = xr_q; end
      OP_AXR_A:           begin mul_a = a_real_q; mul_b = xr_q; end
      OP_AXR_B:           begin mul_a = a_imag_q; mul_b = xi_q; end
      OP_AXI_A:           begin mul_a = a_real_q; mul_b = xi_q; end
      OP_AXI_B:           begin mul_a = a_imag_q; mul_b = xr_q; end
      OP_NUR_A:           begin mul_a = tr_q;     mul_b = ur_q; end
      OP_NUR_B:           begin mul_a = ti_q;     mul_b = ui_q; end
      OP_NUI_A:           begin mul_a = tr_q;     mul_b = ui_q; end
      OP_NUI_B:           begin mul_a = ti_q;     mul_b = ur_q; end
      OP_DEN_A:           begin mul_a = dr_q;     mul_b = dr_q; end
      OP_DEN_B:           begin mul_a = di_q;     mul_b = di_q; end
      OP_QR_A:            begin mul_a = nr_q;     mul_b = dr_q; end
      OP_QR_B:            begin mul_a = ni_q;     mul_b = di_q; end
      OP_QI_A:            begin mul_a = ni_q;     mul_b = dr_q; end
      OP_QI_B:            begin mul_a = nr_q;     mul_b = di_q; end
      default:            begin mul_a = '0;       mul_b = '0;   end
    endcase
  end

  assign prod_d   = mul_a * mul_b;
  assign prod_ext = {prod_q[63], prod_q};

  // exact accumulation: even ops start a sum, odd ops finish it
  always_comb begin
    unique case (op_q)
      OP_SQR_B, OP_AXR_B, OP_NUR_B, OP_QI_B:            acc_d = acc_q - prod_ext;
      OP_NRM_B, OP_SQI_B, OP_AXI_B, OP_NUI_B,
      OP_DEN_B, OP_QR_B:                                 acc_d = acc_q + prod_ext;
      default:                                           acc_d = prod_ext;
    endcase
  end

  // complex product part: saturate, floor shift, saturate
  assign cm = sat32(sat64(acc_d) >>> FRACTION_BITS);

  // squared magnitude in Q24.40
  assign sq_sum = acc_d[NORM_W-1:0];
  always_comb begin
    if (DN > 0) begin
      norm = sq_sum >> DN;
    end else if (UP > 0) begin
      norm = (sq_sum > (NORM_MAX >> UP)) ? NORM_MAX : (sq_sum << UP);
    end else begin
      norm = sq_sum;
    end
  end
  assign in_band = (norm < large_norm_q) && (norm > small_norm_q);

  // divider launch: magnitude, overflow test and dividend split
  assign mag_r = qr_q[63] ? (64'd0 - qr_q) : qr_q;
  assign mag_i = qi_q[63] ? (64'd0 - qi_q) : qi_q;
  assign dvd_r = DVD_W'(mag_r) << FRACTION_BITS;
  assign dvd_i = DVD_W'(mag_i) << FRACTION_BITS;

  always_comb begin
    div_in_r.valid = (state_q == S_DIVST);
    div_in_r.rem   = NORM_W'(dvd_r >> QUOT_BITS);
    div_in_r.low   = dvd_r[QUOT_BITS-1:0];
    div_in_r.quot  = '0;
    div_in_i.valid = (state_q == S_DIVST);
    div_in_i.rem   = NORM_W'(dvd_i >> QUOT_BITS);
    div_in_i.low   = dvd_i[QUOT_BITS-1:0];
    div_in_i.quot  = '0;
  end

  rmet_div_chain u_div_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .den_i   (den_q),
    .stage_i (div_in_r),
    .stage_o (div_out_r)
  );

  rmet_div_chain u_div_i (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .den_i   (den_q),
    .stage_i (div_in_i),
    .stage_o (div_out_i)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc) state_d = S_CHECK;
      S_CHECK: state_d = (at_limit || blown_q) ? S_DONE : S_MUL;
      S_MUL:   state_d = S_ACC;
      S_ACC: begin
        priority if (op_q == OP_NRM_B && !in_band) state_d = S_DONE;
        else if (op_q == OP_DEN_B && sq_sum == '0) state_d = S_CHECK;
        else if (op_q == OP_QI_B)                  state_d = S_DIVST;
        else                                       state_d = S_MUL;
      end
      S_DIVST: state_d = S_DIVW;
      S_DIVW:  if (div_out_r.valid) state_d = S_CHECK;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_NRM_A;
      iter_q  <= '0;
      blown_q <= 1'b0;
      kind_q  <= KIND_LIMIT;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: if (in_acc) begin
          iter_q  <= '0;
          blown_q <= 1'b0;
        end
        S_CHECK: begin
          op_q <= OP_NRM_A;
          if (at_limit)     kind_q <= KIND_LIMIT;
          else if (blown_q) kind_q <= KIND_OUTWARD;
        end
        S_ACC: begin
          if (op_q != OP_QI_B) op_q <= op_e'(op_q + 5'd1);
          if (op_q == OP_NRM_B) kind_q <= (norm > NORM_ONE) ? KIND_OUTWARD : KIND_INWARD;
          // x equal to a: step counts, next check reports outward unless the limit is reached
          if (op_q == OP_DEN_B && sq_sum == '0) begin
            blown_q <= 1'b1;
            iter_q  <= iter_q + 1'b1;
          end
        end
        S_DIVW: if (div_out_r.valid) iter_q <= iter_q + 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: if (in_acc) begin
        xr_q <= in_i.start_real;
        xi_q <= in_i.start_imag;
      end
      S_MUL: prod_q <= prod_d;
      S_ACC: begin
        acc_q <= acc_d;
        unique case (op_q)
          OP_NRM_A: begin
            dr_q <= sat32(sx64(xr_q) - sx64(a_real_q));
            di_q <= sat32(sx64(xi_q) - sx64(a_imag_q));
          end
          OP_SQR_B: tr_q  <= cm;
          OP_SQI_B: ti_q  <= cm;
          OP_AXR_B: ur_q  <= sat32(sx64(cm) - ONE);
          OP_AXI_B: ui_q  <= cm;
          OP_NUR_B: nr_q  <= cm;
          OP_NUI_B: ni_q  <= cm;
          OP_DEN_B: den_q <= sq_sum;
          OP_QR_B:  qr_q  <= sat64(acc_d);
          OP_QI_B:  qi_q  <= sat64(acc_d);
          default: ;
        endcase
      end
      S_DIVST: begin
        neg_r_q <= qr_q[63];
        neg_i_q <= qi_q[63];
        ovf_r_q <= ((OVF_W'(mag_r) << FRACTION_BITS) >= (OVF_W'(den_q) << QUOT_BITS));
        ovf_i_q <= ((OVF_W'(mag_i) << FRACTION_BITS) >= (OVF_W'(den_q) << QUOT_BITS));
      end
      S_DIVW: if (div_out_r.valid) begin
        xr_q <= quot_fin(ovf_r_q, neg_r_q, div_out_r.quot);
        xi_q <= quot_fin(ovf_i_q, neg_i_q, div_out_i.quot);
      end
      default: ;
    endcase
  end

  // colour code from count and kind
  assign iter_ext = COLOUR_W'(iter_q);
  always_comb begin
    unique case (kind_q)
      KIND_OUTWARD: colour_d = (iter_ext << 3) + (iter_ext << 1);
      KIND_INWARD:  colour_d = (iter_ext << 3) + (iter_ext << 1) + COLOUR_W'(COLOUR_INWARD);
      default:      colour_d = COLOUR_NONE;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      colour_q   <= colour_d;
      iter_out_q <= iter_q;
      kind_out_q <= kind_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.colour_code     = colour_q;
  assign out_o.iterations_done = iter_out_q;
  assign out_o.escape_kind     = kind_out_q;

endmodule

// ----- src/rmet_div_cell.sv -----
// ----------------------------------------------------------------------------
// rmet_div_cell
// One restoring division step: shifts in the next dividend bit, subtracts
// the divisor when it fits and hands the slot to the next cell.
// ----------------------------------------------------------------------------
module rmet_div_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [rmet_pkg::NORM_W-1:0]   den_i,
  input  rmet_pkg::div_stage_t          stage_i,
  output rmet_pkg::div_stage_t          stage_o
);
  import rmet_pkg::*;

  logic [NORM_W:0]      trial;
  logic [NORM_W:0]      diff;
  logic                 take;
  div_stage_t           stage_d;
  logic                 valid_q;
  logic [NORM_W-1:0]    rem_q;
  logic [QUOT_BITS-1:0] low_q;
  logic [QUOT_BITS-1:0] quot_q;

  // trial subtract
  always_comb begin
    trial         = {stage_i.rem, stage_i.low[QUOT_BITS-1]};
    diff          = trial - {1'b0, den_i};
    take          = (trial >= {1'b0, den_i});
    stage_d.valid = stage_i.valid;
    stage_d.rem   = take ? diff[NORM_W-1:0] : trial[NORM_W-1:0];
    stage_d.low   = {stage_i.low[QUOT_BITS-2:0], 1'b0};
    stage_d.quot  = {stage_i.quot[QUOT_BITS-2:0], take};
  end

  // slot valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_d.valid;
    end
  end

  // slot payload
  always_ff @(posedge clk_i) begin
    rem_q  <= stage_d.rem;
    low_q  <= stage_d.low;
    quot_q <= stage_d.quot;
  end

  assign stage_o.valid = valid_q;
  assign stage_o.rem   = rem_q;
  assign stage_o.low   = low_q;
  assign stage_o.quot  = quot_q;

endmodule

// ----- src/rmet_div_chain.sv -----
// ----------------------------------------------------------------------------
// rmet_div_chain
// Row of division cells, one quotient bit per cell; a slot entering the
// first cell is registered in each cell in turn until it leaves the last one.
// ----------------------------------------------------------------------------
module rmet_div_chain (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [rmet_pkg::NORM_W-1:0]   den_i,
  input  rmet_pkg::div_stage_t          stage_i,
  output rmet_pkg::div_stage_t          stage_o
);
  import rmet_pkg::*;

  div_stage_t link [QUOT_BITS+1];

  assign link[0] = stage_i;

  for (genvar g = 0; g < QUOT_BITS; g++) begin : g_cell
    rmet_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .den_i   (den_i),
      .stage_i (link[g]),
      .stage_o (link[g+1])
    );
  end

  assign stage_o = link[QUOT_BITS];

endmodule

// ----- src/rmet_checker.sv -----
// ----------------------------------------------------------------------------
// rmet_checker
// Port-level checks of the escape-time core: result holding, busy after an
// item is taken, and consistency of colour code with count and kind.
// ----------------------------------------------------------------------------
module rmet_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [rmet_pkg::COLOUR_W-1:0]   colour_code_i,
  input logic [rmet_pkg::ITER_W-1:0]     iterations_done_i,
  input logic [1:0]                      escape_kind_i
);
  import rmet_pkg::*;
  `include "rational_map_escape_time_core_assert.svh"

  // a waiting result is not withdrawn
  `RMET_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")

  // one item at a time: busy right after taking one
  `RMET_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "input taken while busy")

  // colour code agrees with kind and count
  `RMET_ASSERT_IMPL(a_limit_colour, clk_i, rst_ni, out_valid_i && escape_kind_i == KIND_LIMIT, colour_code_i == COLOUR_NONE, "limit colour wrong")
  `RMET_ASSERT_IMPL(a_outward_colour, clk_i, rst_ni, out_valid_i && escape_kind_i == KIND_OUTWARD, colour_code_i == COLOUR_W'(COLOUR_STEP * iterations_done_i), "outward colour wrong")
  `RMET_ASSERT_IMPL(a_inward_colour, clk_i, rst_ni, out_valid_i && escape_kind_i == KIND_INWARD, colour_code_i == COLOUR_W'(COLOUR_STEP * iterations_done_i + COLOUR_INWARD), "inward colour wrong")

endmodule

bind rational_map_escape_time_core rmet_checker u_rmet_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .colour_code_i     (out_o.colour_code),
  .iterations_done_i (out_o.iterations_done),
  .escape_kind_i     (out_o.escape_kind)
);

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rational map escape-time core. Start points go
// in through a queue-fed driver, a monitor predicts each result with its own
// fixed-point model of the map and compares it field by field, and the map
// parameter, limit and norm band are reprogrammed over the APB-style port
// between phases while the core is idle.
// ----------------------------------------------------------------------------
module testbench;
  import rmet_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FB         = FRACTION_BITS_DEF;
  localparam int unsigned NORM_DOWN  = (2 * FB > NORM_FRAC) ? 2 * FB - NORM_FRAC : 0;
  localparam int unsigned NORM_UP    = (2 * FB < NORM_FRAC) ? NORM_FRAC - 2 * FB : 0;
  localparam longint      CYCLE_CAP  = 8000000;
  localparam int unsigned SETTLE_CYC = 600;

  typedef enum int unsigned {
    REG_A_REAL     = 0,
    REG_A_IMAG     = 1,
    REG_ITER_LIMIT = 2,
    REG_SMALL_NORM = 3,
    REG_LARGE_NORM = 4
  } reg_index_e;

  typedef struct {
    logic signed [POINT_W-1:0] re;
    logic signed [POINT_W-1:0] im;
  } point_t;

  typedef struct {
    logic [COLOUR_W-1:0] colour;
    logic [ITER_W-1:0]   iters;
    escape_kind_e        kind;
  } escape_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  rmet_in_if  in_ch ();
  rmet_out_if out_ch ();

  rational_map_escape_time_core uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_ch.sink),
    .out_o   (out_ch.source)
  );

  // shadow copy of the register file
  longint              a_re;
  longint              a_im;
  logic [ITER_W-1:0]   iter_limit;
  longint unsigned     band_lo;
  longint unsigned     band_hi;

  point_t  points_pending[$];
  escape_t escapes_due[$];
  int      mismatches;
  int      pushed_count;
  int      accepted_count;
  longint  cycle_count;
  bit      calm;
  int      tx_wait;
  int      rx_wait;

  // clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------- arithmetic
  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint add_sat(longint p, longint q);
    logic signed [64:0] s;
    s = $signed({p[63], p}) + $signed({q[63], q});
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  // complex product, floor shift, saturated parts
  function automatic void cmul(input longint ar, ai, br, bi, output longint rr, ri);
    rr = sat32(add_sat(ar * br, -(ai * bi)) >>> FB);
    ri = sat32(add_sat(ar * bi, ai * br) >>> FB);
  endfunction

  function automatic longint unsigned frac_div(longint unsigned mag, longint unsigned den);
    longint unsigned cap;
    longint unsigned q;
    longint unsigned rem;
    cap = 64'd1 << 31;
    q   = mag / den;
    rem = mag % den;
    if (q >= cap) return cap;
    for (int k = 0; k < FB; k++) begin
      if (rem >= den - rem) begin
        rem = rem - (den - rem);
        q   = q * 2 + 1;
      end else begin
        rem = rem * 2;
        q   = q * 2;
      end
      if (q >= cap) return cap;
    end
    return q;
  endfunction

  function automatic longint signed_div(longint num, longint unsigned den);
    longint unsigned m;
    if (num >= 0) return sat32(longint'(frac_div(num, den)));
    m = 64'd0 - num;
    return sat32(-longint'(frac_div(m, den)));
  endfunction

  function automatic longint unsigned norm_sq(longint xr, longint xi);
    longint unsigned s;
    s = longint'(xr * xr) + longint'(xi * xi);
    if (NORM_DOWN > 0) return s >> NORM_DOWN;
    if (NORM_UP > 0) begin
      if (s > ({64{1'b1}} >> NORM_UP)) return {64{1'b1}};
      return s << NORM_UP;
    end
    return s;
  endfunction

  // escape-time result of one start point under the shadow registers
  function automatic escape_t escape_of(point_t p);
    escape_t r;
    longint xr, xi, tr, ti, axr, axi, ur, ui, nr, ni, dr, di;
    longint unsigned den, n, top;
    int unsigned i;
    bit blown;
    xr    = p.re;
    xi    = p.im;
    top   = (iter_limit > ITER_CEILING) ? ITER_CEILING : iter_limit;
    i     = 0;
    blown = 1'b0;
    while (i < top && !blown) begin
      n = norm_sq(xr, xi);
      if (!(n < band_hi && n > band_lo)) break;
      cmul(xr, xi, xr, xi, tr, ti);
      cmul(a_re, a_im, xr, xi, axr, axi);
      ur = sat32(axr - (64'sd1 <<< FB));
      ui = axi;
      cmul(tr, ti, ur, ui, nr, ni);
      dr  = sat32(xr - a_re);
      di  = sat32(xi - a_im);
      den = longint'(dr * dr) + longint'(di * di);
      if (den == 0) begin
        blown = 1'b1;
      end else begin
        xr = signed_div(add_sat(nr * dr, ni * di), den);
        xi = signed_div(add_sat(ni * dr, -(nr * di)), den);
      end
      i++;
    end
    r.iters = i[ITER_W-1:0];
    if (i < top) begin
      if (blown || norm_sq(xr, xi) > (64'd1 << NORM_FRAC)) begin
        r.colour = COLOUR_W'(i * COLOUR_STEP);
        r.kind   = KIND_OUTWARD;
      end else begin
        r.colour = COLOUR_W'(i * COLOUR_STEP + COLOUR_INWARD);
        r.kind   = KIND_INWARD;
      end
    end else begin
      r.colour = COLOUR_NONE;
      r.kind   = KIND_LIMIT;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report(input string what, input longint got, input longint want);
    mismatches++;
    $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // monitor: predict on accepted points, compare accepted results
  always @(posedge clk) begin
    escape_t want;
    point_t  p;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        p.re = in_ch.start_real;
        p.im = in_ch.start_imag;
        escapes_due.push_back(escape_of(p));
        accepted_count++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (escapes_due.size() == 0) begin
          report("unexpected item", out_ch.iterations_done, -1);
        end else begin
          want = escapes_due.pop_front();
          if (out_ch.colour_code !== want.colour)
            report("colour_code", out_ch.colour_code, want.colour);
          if (out_ch.iterations_done !== want.iters)
            report("iterations_done", out_ch.iterations_done, want.iters);
          if (out_ch.escape_kind !== want.kind)
            report("escape_kind", out_ch.escape_kind, want.kind);
        end
      end
    end
  end

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    point_t p;
    bit     took;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      tx_wait = 0;
    end else begin
      took = in_ch.valid && in_ch.ready;
      if (took) tx_wait = calm ? 0 : $urandom_range(0, 4);
      if (!in_ch.valid || took) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_ch.valid <= 1'b0;
        end else if (points_pending.size() > 0) begin
          p = points_pending.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.start_real <= p.re;
          in_ch.start_imag <= p.im;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) rx_wait = calm ? 0 : $urandom_range(0, 4);
      else if (rx_wait > 0) rx_wait--;
      out_ch.ready <= (rx_wait == 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequencing
  task automatic reg_write(input reg_index_e idx, input logic [PDATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx * 8);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_A_REAL:     a_re = $signed(value[31:0]);
      REG_A_IMAG:     a_im = $signed(value[31:0]);
      REG_ITER_LIMIT: iter_limit = value[ITER_W-1:0];
      REG_SMALL_NORM: band_lo = value;
      REG_LARGE_NORM: band_hi = value;
      default: ;
    endcase
  endtask

  task automatic add_point(input longint re, input longint im);
    point_t p;
    p.re = re[31:0];
    p.im = im[31:0];
    points_pending.push_back(p);
    pushed_count++;
  endtask

  // sender holds off until every result is back
  task automatic drain();
    do @(negedge clk); while (accepted_count != pushed_count || escapes_due.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  function automatic longint near_point();
    return longint'($urandom_range(0, 32'h0400_0000)) - 64'sd33554432;
  endfunction

  function automatic longint any_point();
    return $signed(32'($urandom()));
  endfunction

  initial begin
    longint re, im;
    rst_n        = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_ch.valid  = 1'b0;
    in_ch.start_real = '0;
    in_ch.start_imag = '0;
    out_ch.ready = 1'b0;
    mismatches   = 0;
    pushed_count = 0;
    accepted_count = 0;
    cycle_count  = 0;
    calm         = 1'b0;
    a_re         = A_REAL_RST;
    a_im         = A_IMAG_RST;
    iter_limit   = ITER_LIMIT_RST;
    band_lo      = SMALL_NORM_RST;
    band_hi      = LARGE_NORM_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: zero, unit, division by zero at x = a, field extremes
    add_point(0, 0);
    add_point(64'sd1 <<< FB, 0);
    add_point(0, A_IMAG_RST);
    add_point(-(64'sd1 <<< FB), 0);
    add_point(64'sd8388608, 64'sd8388608);
    add_point(64'sd2147483647, 64'sd2147483647);
    add_point(-64'sd2147483648, -64'sd2147483648);
    add_point(-64'sd2147483648, 64'sd2147483647);
    add_point(64'sd20000, 0);
    add_point(64'sd16777, 64'sd1);
    add_point(64'sd3, 64'sd5000000);
    add_point(64'sd25165824, -64'sd4194304);
    drain();

    // limit zero: nothing applied
    reg_write(REG_ITER_LIMIT, 0);
    add_point(64'sd8388608, 0);
    add_point(0, 0);
    add_point(64'sd2147483647, -64'sd2147483648);
    drain();

    // limit one with a at its extremes
    calm = 1'b1;
    reg_write(REG_ITER_LIMIT, 1);
    reg_write(REG_A_REAL, 64'h7FFF_FFFF);
    reg_write(REG_A_IMAG, 64'h8000_0000);
    add_point(64'sd2147483647, -64'sd2147483648);
    add_point(64'sd8388608, 64'sd8388608);
    add_point(-64'sd16777216, 64'sd1);
    drain();

    // widest band and the largest limit
    calm = 1'b0;
    reg_write(REG_A_REAL, 0);
    reg_write(REG_A_IMAG, A_IMAG_RST);
    reg_write(REG_SMALL_NORM, 0);
    reg_write(REG_LARGE_NORM, {PDATA_W{1'b1}});
    reg_write(REG_ITER_LIMIT, ITER_CEILING);
    add_point(0, A_IMAG_RST);
    add_point(64'sd2147483647, 64'sd2147483647);
    add_point(64'sd12582912, 64'sd4194304);
    drain();

    // empty band: every point stops at once
    reg_write(REG_SMALL_NORM, {PDATA_W{1'b1}});
    reg_write(REG_LARGE_NORM, 0);
    add_point(64'sd16777216, 0);
    add_point(64'sd100, -64'sd100);
    drain();

    reg_write(REG_SMALL_NORM, SMALL_NORM_RST);
    reg_write(REG_LARGE_NORM, LARGE_NORM_RST);

    // random phases with fresh map parameters and small limits
    for (int ph = 0; ph < 6; ph++) begin
      calm = (ph == 2);
      if (ph % 3 == 2) begin
        reg_write(REG_A_REAL, $urandom());
        reg_write(REG_A_IMAG, $urandom());
      end else begin
        reg_write(REG_A_REAL, near_point());
        reg_write(REG_A_IMAG, near_point());
      end
      reg_write(REG_ITER_LIMIT, (ph == 5) ? ITER_LIMIT_RST : $urandom_range(1, 30));
      if (ph == 4) reg_write(REG_SMALL_NORM, $urandom_range(0, 1 << 24));
      for (int k = 0; k < 63; k++) begin
        case ($urandom_range(0, 15))
          0: begin
            re = a_re;
            im = a_im;
          end
          1, 2, 3: begin
            re = any_point();
            im = any_point();
          end
          default: begin
            re = near_point();
            im = near_point();
          end
        endcase
        add_point(re, im);
      end
      drain();
    end

    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- rational_map_escape_time_core.f -----
+incdir+src
src/rmet_pkg.sv
src/rmet_if.sv
src/rmet_div_cell.sv
src/rmet_div_chain.sv
src/rational_map_escape_time_core.sv
src/rmet_checker.sv
bench/testbench.sv
